/* rtl/pdr_pkg.sv */
// Shared types and constants of the PID duty regulator.
`default_nettype none

package pdr_pkg;

	// Fixed field widths
	localparam int SETPOINT_W = 16;
	localparam int DUTY_W     = 16;
	localparam int GAIN_W     = 32;
	localparam int COEF_W     = GAIN_W + 2;
	localparam int MODE_W     = 2;
	localparam int IDX_W      = 3;

	// Register indexes of the configuration channel
	localparam logic [IDX_W-1:0] REG_SETPOINT = 3'd0;
	localparam logic [IDX_W-1:0] REG_MODE     = 3'd1;
	localparam logic [IDX_W-1:0] REG_KP       = 3'd2;
	localparam logic [IDX_W-1:0] REG_KI       = 3'd3;
	localparam logic [IDX_W-1:0] REG_KD       = 3'd4;
	localparam logic [IDX_W-1:0] REG_DUTY_MIN = 3'd5;
	localparam logic [IDX_W-1:0] REG_DUTY_MAX = 3'd6;

	// Regulated quantity select
	localparam logic [MODE_W-1:0] MODE_IN_CURRENT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_IN_VOLTAGE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_OUT_VOLTAGE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_OUT_CURRENT = 2'd3;

	localparam logic [DUTY_W-1:0] DUTY_MAX_RESET = 16'hFFFF;

	// Settings and derived PID coefficients seen by the datapath
	typedef struct packed {
		logic [SETPOINT_W-1:0]    setpoint;
		logic [MODE_W-1:0]        mode;
		logic [DUTY_W-1:0]        duty_min;
		logic [DUTY_W-1:0]        duty_max;
		logic signed [COEF_W-1:0] a0;
		logic signed [COEF_W-1:0] a1;
		logic signed [GAIN_W-1:0] a2;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/pdr_cfg_regs.sv */
// Configuration registers and derived incremental PID coefficients.
`default_nettype none

module pdr_cfg_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [pdr_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [pdr_pkg::GAIN_W-1:0]  cfg_data,
	output pdr_pkg::cfg_t                    cfg
);

	logic [pdr_pkg::SETPOINT_W-1:0]    setpoint_q;
	logic [pdr_pkg::MODE_W-1:0]        mode_q;
	logic signed [pdr_pkg::GAIN_W-1:0] kp_q;
	logic signed [pdr_pkg::GAIN_W-1:0] ki_q;
	logic signed [pdr_pkg::GAIN_W-1:0] kd_q;
	logic [pdr_pkg::DUTY_W-1:0]        duty_min_q;
	logic [pdr_pkg::DUTY_W-1:0]        duty_max_q;
	logic signed [pdr_pkg::COEF_W-1:0] a0_q;
	logic signed [pdr_pkg::COEF_W-1:0] a1_q;
	logic signed [pdr_pkg::GAIN_W-1:0] a2_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= '0;
			mode_q     <= pdr_pkg::MODE_IN_CURRENT;
			kp_q       <= '0;
			ki_q       <= '0;
			kd_q       <= '0;
			duty_min_q <= '0;
			duty_max_q <= pdr_pkg::DUTY_MAX_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				pdr_pkg::REG_SETPOINT: setpoint_q <= cfg_data[pdr_pkg::SETPOINT_W-1:0];
				pdr_pkg::REG_MODE:     mode_q     <= cfg_data[pdr_pkg::MODE_W-1:0];
				pdr_pkg::REG_KP:       kp_q       <= cfg_data;
				pdr_pkg::REG_KI:       ki_q       <= cfg_data;
				pdr_pkg::REG_KD:       kd_q       <= cfg_data;
				pdr_pkg::REG_DUTY_MIN: duty_min_q <= cfg_data[pdr_pkg::DUTY_W-1:0];
				pdr_pkg::REG_DUTY_MAX: duty_max_q <= cfg_data[pdr_pkg::DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// Follow the gains in a register; the user, not the block, lets writes land before the math
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a0_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
		end else begin
			a0_q <= pdr_pkg::COEF_W'(kp_q) + pdr_pkg::COEF_W'(ki_q)
				+ pdr_pkg::COEF_W'(kd_q);
			a1_q <= -pdr_pkg::COEF_W'(kp_q) - (pdr_pkg::COEF_W'(kd_q) <<< 1);
			a2_q <= kd_q;
		end
	end

	always_comb begin
		cfg.setpoint = setpoint_q;
		cfg.mode     = mode_q;
		cfg.duty_min = duty_min_q;
		cfg.duty_max = duty_max_q;
		cfg.a0       = a0_q;
		cfg.a1       = a1_q;
		cfg.a2       = a2_q;
	end

endmodule

`default_nettype wire

/* rtl/pdr_datapath.sv */
// Incremental PID sum, range clamp and error/output history.
`default_nettype none

module pdr_datapath #(
	parameter int ERR_W          = 17,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          advance,
	input  wire logic signed [ERR_W-1:0]       e_s1,
	input  wire pdr_pkg::cfg_t                 cfg,
	output logic [pdr_pkg::DUTY_W-1:0]         compare_value,
	output logic                               clamped
);

	localparam int PROD_W = pdr_pkg::COEF_W + ERR_W;
	localparam int Y_W    = PROD_W + 2;
	localparam int OUT_W  = pdr_pkg::DUTY_W + GAIN_FRAC_BITS;

	logic signed [ERR_W-1:0]  prev_err_q;
	logic signed [ERR_W-1:0]  prev_prev_err_q;
	logic [OUT_W-1:0]         prev_out_q;

	logic signed [PROD_W-1:0] p0;
	logic signed [PROD_W-1:0] p1;
	logic signed [PROD_W-1:0] p2;
	logic signed [Y_W-1:0]    y;
	logic signed [Y_W-1:0]    lo;
	logic signed [Y_W-1:0]    hi;
	logic                     below;
	logic                     above;

	always_comb begin
		p0 = PROD_W'(cfg.a0) * PROD_W'(e_s1);
		p1 = PROD_W'(cfg.a1) * PROD_W'(prev_err_q);
		p2 = PROD_W'(cfg.a2) * PROD_W'(prev_prev_err_q);
		y  = Y_W'(signed'({1'b0, prev_out_q})) + Y_W'(p0) + Y_W'(p1) + Y_W'(p2);
		lo = Y_W'(signed'({1'b0, cfg.duty_min, {GAIN_FRAC_BITS{1'b0}}}));
		hi = Y_W'(signed'({1'b0, cfg.duty_max, {GAIN_FRAC_BITS{1'b0}}}));
		below = y < lo;
		above = y > hi;
		clamped = below | above;
		if (below) begin
			compare_value = cfg.duty_min;
		end else if (above) begin
			compare_value = cfg.duty_max;
		end else begin
			compare_value = y[GAIN_FRAC_BITS +: pdr_pkg::DUTY_W];
		end
	end

	// On each advance, clear history on a clamp, otherwise shift it by one sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q      <= '0;
			prev_prev_err_q <= '0;
			prev_out_q      <= '0;
		end else if (advance) begin
			if (clamped) begin
				prev_err_q      <= '0;
				prev_prev_err_q <= '0;
				prev_out_q      <= '0;
			end else begin
				prev_err_q      <= e_s1;
				prev_prev_err_q <= prev_err_q;
				prev_out_q      <= y[OUT_W-1:0];
			end
		end
	end

	a_clamp_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && clamped |=> prev_err_q == '0 && prev_prev_err_q == '0 && prev_out_q == '0)
		else $error("history not cleared after clamp");

	a_err_shift: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !clamped |=> prev_err_q == $past(e_s1)
			&& prev_prev_err_q == $past(prev_err_q))
		else $error("error history did not shift");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(prev_err_q) && $stable(prev_prev_err_q) && $stable(prev_out_q))
		else $error("history changed without an item");

endmodule

`default_nettype wire

/* rtl/pid_duty_regulator.sv */
// Top level of the incremental PID duty regulator with output clamp.
// Usage:
//   s_axis carries one sample set per transfer; s_axis_tdata holds input_current,
//   input_voltage, output_voltage and output_current, SAMPLE_WIDTH bits each,
//   lowest field first. m_axis returns one result per sample set: the PWM compare
//   value in m_axis_tdata and the clamp flag in m_axis_tuser.
//   The cfg channel writes one register per transfer (cfg_index 0..6: setpoint,
//   mode, kp, ki, kd, duty_min, duty_max); cfg_ready is always high and index 7
//   is ignored. Write it only while no sample set is in flight.
// Pipeline:
//   The input register takes the error of the selected quantity at the input
//   transfer; the PID sum and clamp reach the result register on advance, and
//   m_axis_tvalid comes from the result register. Throughput is one sample set
//   per cycle while the result is taken, set by the combinational PID path whose
//   result feeds the history registers.
// Reset clears all history and the valid flags and loads register defaults
// (duty_max 65535, all others 0).
// When the receiver stalls, hold the result; the input register still takes a
// new set, after which s_axis_tready drops until the result is taken.
`default_nettype none

module pid_duty_regulator #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input_current, input_voltage, output_voltage, output_current (lowest first)
	input  wire logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// compare_value
	output logic [pdr_pkg::DUTY_W-1:0]             m_axis_tdata,
	// clamped
	output logic [0:0]                             m_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [pdr_pkg::IDX_W-1:0]         cfg_index,
	input  wire logic [pdr_pkg::GAIN_W-1:0]        cfg_data
);

	localparam int ERR_W = (SAMPLE_WIDTH > pdr_pkg::SETPOINT_W ?
		SAMPLE_WIDTH : pdr_pkg::SETPOINT_W) + 1;

	pdr_pkg::cfg_t cfg;

	logic                              valid_s1;
	logic signed [ERR_W-1:0]           e_s1;
	logic [SAMPLE_WIDTH-1:0]           sample;
	logic signed [ERR_W-1:0]           e_next;
	logic                              advance;
	logic [pdr_pkg::DUTY_W-1:0]        cmp_next;
	logic                              clamp_next;
	logic                              out_valid_q;
	logic [pdr_pkg::DUTY_W-1:0]        cmp_q;
	logic                              clamped_q;

	pdr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Pick the regulated quantity and form the error at full width
	always_comb begin
		case (cfg.mode)
			pdr_pkg::MODE_IN_CURRENT:  sample = s_axis_tdata[0*SAMPLE_WIDTH +: SAMPLE_WIDTH];
			pdr_pkg::MODE_IN_VOLTAGE:  sample = s_axis_tdata[1*SAMPLE_WIDTH +: SAMPLE_WIDTH];
			pdr_pkg::MODE_OUT_VOLTAGE: sample = s_axis_tdata[2*SAMPLE_WIDTH +: SAMPLE_WIDTH];
			pdr_pkg::MODE_OUT_CURRENT: sample = s_axis_tdata[3*SAMPLE_WIDTH +: SAMPLE_WIDTH];
			default:                   sample = s_axis_tdata[0 +: SAMPLE_WIDTH];
		endcase
		e_next = signed'(ERR_W'(cfg.setpoint)) - signed'(ERR_W'(sample));
	end

	// The input register moves on when the result register is free or being drained
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			e_s1 <= e_next;
		end
	end

	pdr_datapath #(
		.ERR_W          (ERR_W),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.e_s1          (e_s1),
		.cfg           (cfg),
		.compare_value (cmp_next),
		.clamped       (clamp_next)
	);

	// Result register: load on advance, drop valid once the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmp_q     <= cmp_next;
			clamped_q <= clamp_next;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = cmp_q;
	assign m_axis_tuser[0] = clamped_q;

	a_advance_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_axis_tvalid)
		else $error("result lost after advance");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> valid_s1)
		else $error("accepted item not held in input register");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(e_s1))
		else $error("waiting item overwritten");

endmodule

`default_nettype wire
